/* rtl/lzsi_pkg.sv */
// Shared types and constants for the inverted-byte LZSS decoder.
package lzsi_pkg;

  localparam int unsigned WIN_AW = 12;

  localparam logic [WIN_AW-1:0] PTR_START  = 12'hFEE;
  localparam logic [WIN_AW:0]   WIN_DEPTH  = 13'd4096;
  localparam logic [4:0]        MIN_MATCH  = 5'd3;

  // Sequencer request to the history window
  typedef struct packed {
    logic              restart;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
  } win_req_t;

endpackage

/* rtl/lzss_inverted_decoder.sv */
// Top level: inverted-byte LZSS decoder, 4 KiB window, with token sequencer and output register.
// One stored byte per input beat (in_tdata), bit-inverted before use; in_tuser restarts the
// stream first. A flag byte or the first byte of a reference yields no beat. A literal is held
// in S_LIT, then written to the window and loaded into the output register. A reference of
// length 3..18 copies each byte through S_RD and S_WR, set by the single window RAM port: S_RD
// issues the registered read, S_WR writes the byte back and loads the output register. Output
// stalls hold S_LIT and S_WR. The window needs no clearing pass after reset or restart: a fill
// count marks which entries hold data, others read zero.
// out_tlast flags the last byte caused by one input beat. cfg_data sets the output limit
// (0 = unlimited); write it only while the decoder is idle.
module lzss_inverted_decoder import lzsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code_byte
  input  logic        in_tuser,   // [0] stream_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] plain_byte
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]        state_r,    state_nxt;
  logic [31:0]       limit_r;
  logic [31:0]       emitted_r,  emitted_nxt;
  logic [8:0]        flag_r,     flag_nxt;
  logic [7:0]        pend_r,     pend_nxt;
  logic              exp_sec_r,  exp_sec_nxt;
  logic              exp_tok_r,  exp_tok_nxt;
  logic [7:0]        lit_r,      lit_nxt;
  logic [WIN_AW-1:0] rd_addr_r,  rd_addr_nxt;
  logic [4:0]        rem_r,      rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  win_req_t   win_req;
  logic [7:0] win_rd_data;

  logic        in_acc;
  logic        out_free;
  logic [7:0]  v;
  logic [8:0]  f_cur;
  logic [8:0]  flag_shr;
  logic        tok_cur;
  logic        sec_cur;
  logic [31:0] em_cur;
  logic        lim_hit;
  logic        tok_done;
  logic [31:0] emitted_inc;
  logic        lim_after;
  logic        copy_last;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;

  assign v        = ~in_tdata;
  // Token state as seen after an optional restart
  assign f_cur    = in_tuser ? 9'd0  : flag_r;
  assign tok_cur  = in_tuser ? 1'b0  : exp_tok_r;
  assign sec_cur  = in_tuser ? 1'b0  : exp_sec_r;
  assign em_cur   = in_tuser ? 32'd0 : emitted_r;
  assign lim_hit  = (limit_r != 32'd0) && (em_cur >= limit_r);
  assign flag_shr = {1'b0, f_cur[8:1]};
  assign tok_done = (flag_shr <= 9'd1);

  assign emitted_inc = (&emitted_r) ? emitted_r : emitted_r + 32'd1;
  assign lim_after   = (limit_r != 32'd0) && (emitted_inc >= limit_r);
  assign copy_last   = (rem_r == 5'd1) || lim_after;

  always_comb begin
    state_nxt     = state_r;
    emitted_nxt   = emitted_r;
    flag_nxt      = flag_r;
    pend_nxt      = pend_r;
    exp_sec_nxt   = exp_sec_r;
    exp_tok_nxt   = exp_tok_r;
    lit_nxt       = lit_r;
    rd_addr_nxt   = rd_addr_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    win_req         = '0;
    win_req.rd_addr = rd_addr_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          win_req.restart = in_tuser;
          emitted_nxt     = em_cur;
          flag_nxt        = f_cur;
          exp_tok_nxt     = tok_cur;
          exp_sec_nxt     = sec_cur;
          if (!lim_hit) begin
            priority if (!tok_cur) begin
              flag_nxt    = {1'b1, v};
              exp_tok_nxt = 1'b1;
            end else if (sec_cur) begin
              exp_sec_nxt = 1'b0;
              rd_addr_nxt = {v[7:4], pend_r};
              rem_nxt     = {1'b0, v[3:0]} + MIN_MATCH;
              state_nxt   = S_RD;
              if (tok_done) begin
                flag_nxt    = '0;
                exp_tok_nxt = 1'b0;
              end else begin
                flag_nxt = flag_shr;
              end
            end else if (f_cur[0]) begin
              lit_nxt   = v;
              state_nxt = S_LIT;
              if (tok_done) begin
                flag_nxt    = '0;
                exp_tok_nxt = 1'b0;
              end else begin
                flag_nxt = flag_shr;
              end
            end else begin
              pend_nxt    = v;
              exp_sec_nxt = 1'b1;
            end
          end
        end
      end
      S_LIT: begin
        if (out_free) begin
          win_req.wr_en   = 1'b1;
          win_req.wr_data = lit_r;
          emitted_nxt     = emitted_inc;
          out_valid_nxt   = 1'b1;
          out_data_nxt    = lit_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_RD: begin
        win_req.rd_en = 1'b1;
        state_nxt     = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          win_req.wr_en   = 1'b1;
          win_req.wr_data = win_rd_data;
          emitted_nxt     = emitted_inc;
          out_valid_nxt   = 1'b1;
          out_data_nxt    = win_rd_data;
          out_last_nxt    = copy_last;
          if (copy_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_addr_nxt = rd_addr_r + 1'b1;
            rem_nxt     = rem_r - 5'd1;
            state_nxt   = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= '0;
      emitted_r   <= '0;
      flag_r      <= '0;
      pend_r      <= '0;
      exp_sec_r   <= 1'b0;
      exp_tok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emitted_r   <= emitted_nxt;
      flag_r      <= flag_nxt;
      pend_r      <= pend_nxt;
      exp_sec_r   <= exp_sec_nxt;
      exp_tok_r   <= exp_tok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lit_r      <= lit_nxt;
    rd_addr_r  <= rd_addr_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  lzsi_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .rd_data (win_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_WR) |-> (rem_r != 5'd0))
    else $error("copy running with zero bytes left");

  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_WR))
    else $error("window read not followed by write-back");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (win_req.wr_en && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("last beat emitted but sequencer still busy");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    win_req.wr_en |-> out_free)
    else $error("byte emitted into an occupied output register");

  a_flag_shape: assert property (@(posedge clk) disable iff (!rst_n)
    exp_tok_r |-> (flag_r > 9'd1))
    else $error("token expected with flags exhausted");
`endif

endmodule

/* rtl/lzsi_window.sv */
// 4 KiB history window: single RAM, write pointer and fill count masking unwritten entries.
module lzsi_window import lzsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  win_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0]        win_mem [0:(1<<WIN_AW)-1];
  logic [7:0]        rd_q_r;
  logic              hit_r;
  logic              hit_nxt;
  logic [WIN_AW-1:0] wptr_r;
  logic [WIN_AW-1:0] wptr_nxt;
  logic [WIN_AW:0]   fill_r;
  logic [WIN_AW:0]   fill_nxt;
  logic [WIN_AW-1:0] rd_ofs;

  // Written entries form one run starting at PTR_START, fill_r long
  assign rd_ofs  = req.rd_addr - PTR_START;
  assign hit_nxt = {1'b0, rd_ofs} < fill_r;

  always_comb begin
    wptr_nxt = wptr_r;
    fill_nxt = fill_r;
    if (req.restart) begin
      wptr_nxt = PTR_START;
      fill_nxt = '0;
    end else if (req.wr_en) begin
      wptr_nxt = wptr_r + 1'b1;
      if (fill_r != WIN_DEPTH) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= PTR_START;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      win_mem[wptr_r] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= win_mem[req.rd_addr];
      hit_r  <= hit_nxt;
    end
  end

  assign rd_data = hit_r ? rd_q_r : 8'h00;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_DEPTH) else $error("window fill count overflow");

  a_wptr_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != WIN_DEPTH) |-> (wptr_r == PTR_START + fill_r[WIN_AW-1:0]))
    else $error("write pointer out of step with fill count");

  a_no_rw_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.restart |-> !req.wr_en && !req.rd_en)
    else $error("window access during restart");
`endif

endmodule
